// ----- design/msq_pkg.sv -----
// Shared types, constants and codes of the min slot priority queue.
package msq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 16;
	localparam int FIELD_W  = 8;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RETURN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FLOOR_OVER = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SLOT_OVER  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOT  = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FIELD_W-1:0] floor_in;
		logic [FIELD_W-1:0] slot_in;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  taken_floor;
		logic [FIELD_W-1:0]  taken_slot;
		logic                head_valid;
		logic [FIELD_W-1:0]  head_floor;
		logic [FIELD_W-1:0]  head_slot;
	} out_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic             ins;
		logic             take;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

// ----- design/msq_cell.sv -----
// One cell of the sorted chain: holds one entry and trades with its neighbours.
module msq_cell
	import msq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  entry_t     prev,
	input  entry_t     next,
	output entry_t     entry
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic             lt_prev;
	logic             lt_self;

	assign lt_prev = prev.valid && (ctrl.key < prev.key);
	assign lt_self = prev.valid && (!valid_q || (ctrl.key < key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.take) begin
			valid_q <= next.valid;
		end else if (ctrl.ins && (lt_prev || lt_self)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			key_q <= next.key;
		end else if (ctrl.ins && lt_prev) begin
			key_q <= prev.key;
		end else if (ctrl.ins && lt_self) begin
			key_q <= ctrl.key;
		end
	end

	assign entry.valid = valid_q;
	assign entry.key   = key_q;

endmodule

// ----- design/min_slot_priority_queue.sv -----
// Top level of the min slot priority queue: command decode, cell chain and result register.
//
// Usage: a command beat is taken at a rising edge with start high and busy low.
// busy stays low, so a command may be issued in every cycle. The command is add
// (limits checked against max_floor and max_slot), return (no limit check) or take.
// The result beat follows in the cycle after the command, marked by done for
// exactly one cycle; the receiver cannot stall it and must take it then.
// Every result carries the status, the removed entry for a take, and the least
// entry left after the command. Throughput is one command per cycle, set by the
// chain of cells, which keeps the entries sorted with the least in the first cell,
// shifts the entries behind the insertion point back by one place on an insert
// and the whole row forward on a take. The configuration port writes max_floor
// (index 0) or max_slot (index 1) at any edge with cfg_we high. Reset empties
// the queue at once, sets both limits to 255 and clears done.
module min_slot_priority_queue
	import msq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_t                  req,
	output logic                 done,
	output out_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	logic [FIELD_W-1:0]  max_floor_q;
	logic [FIELD_W-1:0]  max_slot_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]    taken_q;

	entry_t              cells [CAPACITY];
	cell_ctrl_t          ctrl;
	logic                accept;
	logic                full;
	logic                empty;
	logic [STATUS_W-1:0] status_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = cells[CAPACITY-1].valid;
	assign empty  = !cells[0].valid;

	always_comb begin
		status_d  = ST_OK;
		ctrl.ins  = 1'b0;
		ctrl.take = 1'b0;
		ctrl.key  = {req.floor_in, req.slot_in};
		case (req.cmd)
			CMD_ADD: begin
				if (req.floor_in > max_floor_q) begin
					status_d = ST_FLOOR_OVER;
				end else if (req.slot_in > max_slot_q) begin
					status_d = ST_SLOT_OVER;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.ins = accept;
				end
			end
			CMD_RETURN: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.ins = accept;
				end
			end
			CMD_TAKE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.take = accept;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		if (i == 0) begin : g_first
			// The first cell sees a valid neighbour holding the smallest key.
			assign prev_e.valid = 1'b1;
			assign prev_e.key   = '0;
		end else begin : g_mid_prev
			assign prev_e = cells[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_mid_next
			assign next_e = cells[i+1];
		end
		msq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.prev   (prev_e),
			.next   (next_e),
			.entry  (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_floor_q <= '1;
			max_slot_q  <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_FLOOR: max_floor_q <= cfg_data;
				CFG_MAX_SLOT:  max_slot_q  <= cfg_data;
				default:       max_floor_q <= max_floor_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			taken_q  <= ctrl.take ? cells[0].key : '0;
		end
	end

	assign done             = done_q;
	assign rsp.status       = status_q;
	assign rsp.taken_floor  = taken_q[KEY_W-1:FIELD_W];
	assign rsp.taken_slot   = taken_q[FIELD_W-1:0];
	assign rsp.head_valid   = cells[0].valid;
	assign rsp.head_floor   = cells[0].valid ? cells[0].key[KEY_W-1:FIELD_W] : '0;
	assign rsp.head_slot    = cells[0].valid ? cells[0].key[FIELD_W-1:0] : '0;

	// The first two cells stay in order, and the last cell is valid only if the one before it is.
	a_head_sorted : assert property (@(posedge clk) disable iff (!arst_n)
		cells[1].valid |-> (cells[0].valid && (cells[0].key <= cells[1].key)))
		else $error("head cells out of order");

	a_tail_packed : assert property (@(posedge clk) disable iff (!arst_n)
		cells[CAPACITY-1].valid |-> cells[CAPACITY-2].valid)
		else $error("gap in the cell chain");

	a_one_result : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("command beat without result beat");

	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result beat without command beat");

	a_empty_take : assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_EMPTY)) |-> !rsp.head_valid)
		else $error("empty status with a head entry");

endmodule

// ----- dv/tb_min_slot_priority_queue.sv -----
// Testbench of the min slot priority queue: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module tb_min_slot_priority_queue
	import msq_pkg::*;
;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int REPORT_LIMIT = 10;

	class slot_queue_scoreboard;
		logic [KEY_W-1:0]   keys[$];
		out_t               expected_q[$];
		logic [FIELD_W-1:0] floor_limit;
		logic [FIELD_W-1:0] slot_limit;
		int                 mismatches;

		function new();
			floor_limit = 8'hFF;
			slot_limit  = 8'hFF;
			mismatches  = 0;
		endfunction

		function void set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
			if (idx == CFG_MAX_FLOOR) begin
				floor_limit = val;
			end else begin
				slot_limit = val;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Keys are held in ascending order, so the least key is always at the front.
		function logic [STATUS_W-1:0] store_key(input logic [FIELD_W-1:0] fl,
			input logic [FIELD_W-1:0] sl);
			int               pos;
			logic [KEY_W-1:0] key;
			if (keys.size() >= CAPACITY) begin
				return ST_FULL;
			end
			key = {fl, sl};
			pos = 0;
			while (pos < keys.size() && keys[pos] <= key) begin
				pos++;
			end
			keys.insert(pos, key);
			return ST_OK;
		endfunction

		function void note_command(input in_t item);
			out_t             exp_res;
			logic [KEY_W-1:0] key;
			exp_res = '0;
			case (item.cmd)
				CMD_ADD: begin
					if (item.floor_in > floor_limit) begin
						exp_res.status = ST_FLOOR_OVER;
					end else if (item.slot_in > slot_limit) begin
						exp_res.status = ST_SLOT_OVER;
					end else begin
						exp_res.status = store_key(item.floor_in, item.slot_in);
					end
				end
				CMD_RETURN: begin
					exp_res.status = store_key(item.floor_in, item.slot_in);
				end
				CMD_TAKE: begin
					if (keys.size() == 0) begin
						exp_res.status = ST_EMPTY;
					end else begin
						key = keys.pop_front();
						exp_res.taken_floor = key[KEY_W-1:FIELD_W];
						exp_res.taken_slot  = key[FIELD_W-1:0];
					end
				end
				default: ;
			endcase
			if (keys.size() != 0) begin
				key = keys[0];
				exp_res.head_valid = 1'b1;
				exp_res.head_floor = key[KEY_W-1:FIELD_W];
				exp_res.head_slot  = key[FIELD_W-1:0];
			end
			expected_q.push_back(exp_res);
		endfunction

		function void check_result(input out_t got);
			out_t exp_res;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: result beat with nothing outstanding: status=%0d", $time,
						got.status);
				end
				return;
			end
			exp_res = expected_q.pop_front();
			if (got.status !== exp_res.status || got.taken_floor !== exp_res.taken_floor ||
				got.taken_slot !== exp_res.taken_slot || got.head_valid !== exp_res.head_valid ||
				got.head_floor !== exp_res.head_floor || got.head_slot !== exp_res.head_slot) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: mismatch: expected status=%0d taken=%0d/%0d head=%0b %0d/%0d",
						$time, exp_res.status, exp_res.taken_floor, exp_res.taken_slot,
						exp_res.head_valid, exp_res.head_floor, exp_res.head_slot);
					$display("%0t:           actual   status=%0d taken=%0d/%0d head=%0b %0d/%0d",
						$time, got.status, got.taken_floor, got.taken_slot,
						got.head_valid, got.head_floor, got.head_slot);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_t                  req;
	logic                 done;
	out_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FIELD_W-1:0]   cfg_data;

	slot_queue_scoreboard sb;
	int                   idle_pct;
	int                   quiet_cycles;

	min_slot_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_result(rsp);
			end
			if (start && !busy) begin
				sb.note_command(req);
			end
		end
		if (arst_n && ((start && !busy) || done)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("tb_min_slot_priority_queue: FAIL");
		$finish;
	end

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] fl,
		input logic [FIELD_W-1:0] sl);
		in_t item;
		item.cmd      = cmd;
		item.floor_in = fl;
		item.slot_in  = sl;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limits(input logic [FIELD_W-1:0] fl, input logic [FIELD_W-1:0] sl);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_FLOOR;
		cfg_data  <= fl;
		@(posedge clk);
		cfg_index <= CFG_MAX_SLOT;
		cfg_data  <= sl;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(CFG_MAX_FLOOR, fl);
		sb.set_limit(CFG_MAX_SLOT, sl);
	endtask

	function automatic logic [FIELD_W-1:0] pick_value(input logic [FIELD_W-1:0] limit);
		int v;
		case ($urandom_range(3))
			0: return FIELD_W'($urandom_range(255));
			1: return FIELD_W'($urandom_range(3));
			2: begin
				v = int'(limit) + int'($urandom_range(4)) - 2;
				if (v < 0) v = 0;
				if (v > 255) v = 255;
				return FIELD_W'(v);
			end
			default: return $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	task automatic run_random(input int count);
		int               remaining;
		int               burst_len;
		int               insert_bias;
		logic [CMD_W-1:0] cmd;
		remaining = count;
		while (remaining > 0) begin
			burst_len = $urandom_range(1, 100);
			case ($urandom_range(2))
				0: insert_bias = 85;
				1: insert_bias = 15;
				default: insert_bias = 50;
			endcase
			for (int i = 0; i < burst_len && remaining > 0; i++) begin
				if ($urandom_range(99) < 3) begin
					cmd = CMD_UNUSED;
				end else if ($urandom_range(99) < insert_bias) begin
					cmd = $urandom_range(1) ? CMD_ADD : CMD_RETURN;
					remaining--;
				end else begin
					cmd = CMD_TAKE;
					remaining--;
				end
				send_command(cmd, pick_value(sb.floor_limit), pick_value(sb.slot_limit));
			end
		end
	endtask

	initial begin
		sb           = new();
		idle_pct     = 0;
		quiet_cycles = 0;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		req          <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_MAX_FLOOR;
		cfg_data     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(CMD_TAKE, 8'h00, 8'h00);
		send_command(CMD_UNUSED, 8'hAA, 8'h55);
		send_command(CMD_ADD, 8'hFF, 8'hFF);
		send_command(CMD_ADD, 8'h00, 8'h00);
		send_command(CMD_RETURN, 8'h00, 8'h00);
		send_command(CMD_RETURN, 8'h00, 8'hFF);
		send_command(CMD_ADD, 8'hFF, 8'h00);
		repeat (6) send_command(CMD_TAKE, 8'hFF, 8'hFF);
		settle();
		write_limits(8'd10, 8'd20);
		send_command(CMD_ADD, 8'd11, 8'd0);
		send_command(CMD_ADD, 8'd11, 8'd21);
		send_command(CMD_ADD, 8'd10, 8'd21);
		send_command(CMD_ADD, 8'd10, 8'd20);
		send_command(CMD_ADD, 8'd0, 8'd0);
		send_command(CMD_RETURN, 8'd200, 8'd255);
		send_command(CMD_UNUSED, 8'hFF, 8'hFF);
		repeat (3) send_command(CMD_TAKE, 8'h00, 8'h00);
		settle();

		write_limits(8'd128, 8'd200);
		idle_pct = 18;
		run_random(500);
		settle();
		write_limits(8'd0, 8'd255);
		idle_pct = 75;
		run_random(500);
		settle();
		write_limits(8'd255, 8'd0);
		idle_pct = 0;
		run_random(500);
		settle();

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_min_slot_priority_queue: PASS");
		end else begin
			$display("tb_min_slot_priority_queue: FAIL");
		end
		$finish;
	end

endmodule
